// ===== sv/tmcw_pkg.sv =====
// Shared constants, request and control codes, and memory port structs
// for the text console writer. No dependencies.
package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TAB_W  = $clog2(TAB_STOP + 1);
  localparam int POS_W  = 11;
  localparam int RA_W   = 16;

  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_BLANK = 8'd0;

  localparam logic [7:0] COLOR_RST = 8'h07;

  typedef struct packed {
    logic              we_char;
    logic              we_color;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        ch;
    logic [7:0]        color;
  } cell_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } cell_rd_t;

endpackage

// ===== sv/tmcw_cell_store.sv =====
// Cell store: character and colour memories, one write and one read port,
// read data registered. Depends on tmcw_pkg.
module tmcw_cell_store import tmcw_pkg::*; (
  input  logic       clk,
  input  cell_wr_t   wr,
  input  cell_rd_t   rd,
  output logic [7:0] rd_char,
  output logic [7:0] rd_color
);

  logic [7:0] char_mem  [CELL_COUNT];
  logic [7:0] color_mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we_char) begin
      char_mem[wr.addr] <= wr.ch;
    end
    if (rd.re) begin
      rd_char <= char_mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_color) begin
      color_mem[wr.addr] <= wr.color;
    end
    if (rd.re) begin
      rd_color <= color_mem[rd.addr];
    end
  end

endmodule

// ===== sv/text_mode_console_writer_core.sv =====
// Top level of the text console writer: request sequencer, cursor and
// sweep engine around the cell store. Depends on tmcw_pkg, tmcw_cell_store.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  request   | start / busy          | req_type, char_code, read_row, read_col
//  result    | done (1-cycle strobe) | cursor_pos, cell_char, cell_color
//  config    | cfg_we                | cfg_wdata (blank colour)
//
// Plain put, CR, LF without scroll, read and the spare code give
// their result the cycle after acceptance, and busy is already low in that
// cycle, so one request per cycle. A tab writes its spaces one at a time and
// gives its result after the last one. Scroll and clear walk the cell memory
// cell by cell through the single write port of the store, with busy high,
// and give their result after the walk. A scroll inside a tab adds the same walk.
// Reset runs the same clearing pass (busy high); config writes
// are taken meanwhile. The receiver cannot stall: done lasts one cycle.
module text_mode_console_writer_core import tmcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [7:0]       char_code,
  input  logic [4:0]       read_row,
  input  logic [6:0]       read_col,
  output logic             done,
  output logic [POS_W-1:0] cursor_pos,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_color,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TAB   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]        state;
  logic [7:0]        fill_color;
  logic [7:0]        sweep_color;   // blank colour latched when a sweep starts
  logic              sweep_clear;   // whole-screen blank rather than scroll
  logic              sweep_report;  // low only for the pass after reset
  logic [ADDR_W-1:0] ptr;
  logic              wr_v;          // delayed write stage of the sweep
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_blank;

  // cursor kept as linear address plus column, and column mod tab stop
  logic [ADDR_W-1:0] lin;
  logic [COL_W-1:0]  col;
  logic [PH_W-1:0]   ph;
  logic [TAB_W-1:0]  tab_left;
  logic              out_read;

  logic [7:0] rd_char;
  logic [7:0] rd_color;
  cell_wr_t   cell_wr;
  cell_rd_t   cell_rd;

  logic            accept;
  logic            at_row_end;
  logic            at_last;
  logic            put_plain;
  logic            rd_in_range;
  logic [RA_W-1:0] rd_addr_full;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign at_row_end = (col == COL_W'(COLUMNS - 1));
  assign at_last    = (lin == LAST_CELL);
  assign put_plain  = accept && (req_type == REQ_PUT) && (char_code != CH_TAB)
                      && (char_code != CH_LF) && (char_code != CH_CR);

  assign rd_in_range  = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
  assign rd_addr_full = RA_W'(read_row) * RA_W'(COLUMNS) + RA_W'(read_col);

  assign cursor_pos = POS_W'(lin);
  assign cell_char  = out_read ? rd_char  : 8'd0;
  assign cell_color = out_read ? rd_color : 8'd0;

  // write port: sweep stage, glyph put, tab space; never two at once
  always_comb begin
    cell_wr = '0;
    priority if (wr_v) begin
      cell_wr.we_char  = 1'b1;
      cell_wr.we_color = 1'b1;
      cell_wr.addr     = wr_addr;
      cell_wr.ch       = wr_blank ? CH_BLANK : rd_char;
      cell_wr.color    = wr_blank ? sweep_color : rd_color;
    end else if (put_plain) begin
      cell_wr.we_char = 1'b1;
      cell_wr.addr    = lin;
      cell_wr.ch      = char_code;
    end else if (state == ST_TAB) begin
      cell_wr.we_char = 1'b1;
      cell_wr.addr    = lin;
      cell_wr.ch      = CH_SPACE;
    end else begin
      // port idle
    end
  end

  // read port: source row of a scroll copy, or the cell of a read request
  always_comb begin
    cell_rd = '0;
    priority if (state == ST_SWEEP) begin
      cell_rd.re   = !sweep_clear && (ptr < COPY_END);
      cell_rd.addr = ptr + ROW_STEP;
    end else if (accept && (req_type == REQ_READ)) begin
      cell_rd.re   = 1'b1;
      cell_rd.addr = rd_addr_full[ADDR_W-1:0];
    end else begin
      // port idle
    end
  end

  tmcw_cell_store u_store (
    .clk      (clk),
    .wr       (cell_wr),
    .rd       (cell_rd),
    .rd_char  (rd_char),
    .rd_color (rd_color)
  );

  // sweep write stage: payload only
  always_ff @(posedge clk) begin
    wr_addr  <= ptr;
    wr_blank <= sweep_clear || (ptr >= COPY_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      fill_color    <= COLOR_RST;
      sweep_color   <= COLOR_RST;
      sweep_clear   <= 1'b1;
      sweep_report  <= 1'b0;
      ptr           <= '0;
      wr_v          <= 1'b0;
      lin           <= '0;
      col           <= '0;
      ph            <= '0;
      tab_left      <= '0;
      done          <= 1'b0;
      out_read      <= 1'b0;
    end else begin
      done     <= 1'b0;
      out_read <= 1'b0;
      wr_v     <= 1'b0;
      if (cfg_we) begin
        fill_color <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req_type)
              REQ_PUT: begin
                priority if (char_code == CH_LF) begin
                  col <= '0;
                  ph  <= '0;
                  if (lin >= LAST_BASE) begin
                    lin          <= LAST_BASE;
                    state        <= ST_SWEEP;
                    sweep_clear  <= 1'b0;
                    sweep_report <= 1'b1;
                    sweep_color  <= fill_color;
                    ptr          <= '0;
                  end else begin
                    lin  <= lin - ADDR_W'(col) + ROW_STEP;
                    done <= 1'b1;
                  end
                end else if (char_code == CH_CR) begin
                  lin  <= lin - ADDR_W'(col);
                  col  <= '0;
                  ph   <= '0;
                  done <= 1'b1;
                end else if (char_code == CH_TAB) begin
                  tab_left <= TAB_W'(TAB_STOP) - TAB_W'(ph);
                  state    <= ST_TAB;
                end else begin
                  if (at_row_end && at_last) begin
                    lin          <= LAST_BASE;
                    col          <= '0;
                    ph           <= '0;
                    state        <= ST_SWEEP;
                    sweep_clear  <= 1'b0;
                    sweep_report <= 1'b1;
                    sweep_color  <= fill_color;
                    ptr          <= '0;
                  end else begin
                    lin  <= lin + ADDR_W'(1);
                    col  <= at_row_end ? '0 : col + COL_W'(1);
                    ph   <= (at_row_end || ph == PH_W'(TAB_STOP - 1)) ? '0 : ph + PH_W'(1);
                    done <= 1'b1;
                  end
                end
              end
              REQ_READ: begin
                done     <= 1'b1;
                out_read <= rd_in_range;
              end
              REQ_CLEAR: begin
                lin          <= '0;
                col          <= '0;
                ph           <= '0;
                state        <= ST_SWEEP;
                sweep_clear  <= 1'b1;
                sweep_report <= 1'b1;
                sweep_color  <= fill_color;
                ptr          <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_TAB: begin
          // one space per cycle outside a scroll, wrapping and scrolling like a glyph
          tab_left <= tab_left - TAB_W'(1);
          if (at_row_end && at_last) begin
            lin          <= LAST_BASE;
            col          <= '0;
            ph           <= '0;
            state        <= ST_SWEEP;
            sweep_clear  <= 1'b0;
            sweep_report <= 1'b1;
            sweep_color  <= fill_color;
            ptr          <= '0;
          end else begin
            lin <= lin + ADDR_W'(1);
            col <= at_row_end ? '0 : col + COL_W'(1);
            ph  <= (at_row_end || ph == PH_W'(TAB_STOP - 1)) ? '0 : ph + PH_W'(1);
            if (tab_left == TAB_W'(1)) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          wr_v <= 1'b1;
          ptr  <= ptr + ADDR_W'(1);
          if (ptr == LAST_CELL) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last sweep write lands this cycle
          priority if (!sweep_report) begin
            state <= ST_IDLE;
          end else if (!sweep_clear && (tab_left != '0)) begin
            state <= ST_TAB;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result is only ever shown with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  // every accepted request either completes next cycle or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted request lost");

  // glyph writes never collide with a memory sweep
  a_sweep_excl: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SWEEP) || (state == ST_DRAIN)) && cell_wr.we_char |-> wr_v)
    else $error("glyph write during sweep");

  // cursor stays on screen and column is no larger than the linear address
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (lin < ADDR_W'(CELL_COUNT)) && (ADDR_W'(col) <= lin))
    else $error("cursor off screen");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for text_mode_console_writer_core: directed and random
// console requests checked against a cycle-free shadow of the screen and cursor.
// Depends on tmcw_pkg and the core RTL.
import tmcw_pkg::*;

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] code;
  logic [4:0] row;
  logic [6:0] col;
} console_req_t;

typedef struct packed {
  logic [POS_W-1:0] pos;
  logic [7:0]       ch;
  logic [7:0]       color;
} cell_report_t;

// Shadow copy of the console: cursor, cell store and blank colour, plus the
// queue of reports still owed by the core.
class console_shadow;
  logic [7:0]   blank_color;
  int unsigned  cur_col;
  int unsigned  cur_row;
  logic [15:0]  cells [CELL_COUNT];
  cell_report_t owed_reports [$];
  int unsigned  errors;

  function new();
    blank_color = COLOR_RST;
    errors      = 0;
    clear_all();
  endfunction

  function void clear_all();
    for (int unsigned i = 0; i < CELL_COUNT; i++) cells[i] = {blank_color, CH_BLANK};
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Column wrap, then scroll up one row once the cursor falls off the bottom.
  function void settle();
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      for (int unsigned i = 0; i + COLUMNS < CELL_COUNT; i++) cells[i] = cells[i + COLUMNS];
      for (int unsigned i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
        cells[i] = {blank_color, CH_BLANK};
      cur_row = ROWS - 1;
    end
  endfunction

  // Character byte only; the cell keeps its colour.
  function void put_glyph(input logic [7:0] ch);
    int unsigned idx;
    idx = cur_row * COLUMNS + cur_col;
    cells[idx][7:0] = ch;
    cur_col++;
    settle();
  endfunction

  function void note_request(input console_req_t r);
    cell_report_t rep;
    int unsigned  n;
    rep.ch    = '0;
    rep.color = '0;
    case (r.kind)
      REQ_PUT: begin
        case (r.code)
          CH_LF: begin
            cur_col = 0;
            cur_row++;
            settle();
          end
          CH_CR: cur_col = 0;
          CH_TAB: begin
            n = TAB_STOP - (cur_col % TAB_STOP);
            for (int unsigned k = 0; k < n; k++) put_glyph(CH_SPACE);
          end
          default: put_glyph(r.code);
        endcase
      end
      REQ_READ: begin
        if (r.row < ROWS && r.col < COLUMNS) begin
          rep.ch    = cells[r.row * COLUMNS + r.col][7:0];
          rep.color = cells[r.row * COLUMNS + r.col][15:8];
        end
      end
      REQ_CLEAR: clear_all();
      default: ;
    endcase
    rep.pos = POS_W'(cur_row * COLUMNS + cur_col);
    owed_reports.push_back(rep);
  endfunction

  function void check_result(input logic [POS_W-1:0] pos, input logic [7:0] ch,
                             input logic [7:0] color);
    cell_report_t want;
    if (owed_reports.size() == 0) begin
      $error("unexpected result: cursor_pos %0d cell_char %0d cell_color %0d", pos, ch, color);
      errors++;
      return;
    end
    want = owed_reports.pop_front();
    if (pos !== want.pos) begin
      $error("cursor_pos: expected %0d, got %0d", want.pos, pos);
      errors++;
    end
    if (ch !== want.ch) begin
      $error("cell_char: expected %0d, got %0d", want.ch, ch);
      errors++;
    end
    if (color !== want.color) begin
      $error("cell_color: expected %0d, got %0d", want.color, color);
      errors++;
    end
  endfunction
endclass

module testbench;
  // Request code the core must treat as a no-op.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int unsigned PHASE_ITEMS = 260;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [1:0]       req_type  = REQ_PUT;
  logic [7:0]       char_code = 8'd0;
  logic [4:0]       read_row  = 5'd0;
  logic [6:0]       read_col  = 7'd0;
  logic             cfg_we    = 1'b0;
  logic [7:0]       cfg_wdata = 8'd0;
  logic             busy;
  logic             done;
  logic [POS_W-1:0] cursor_pos;
  logic [7:0]       cell_char;
  logic [7:0]       cell_color;

  console_shadow shadow;

  always #4 clk = ~clk;

  text_mode_console_writer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_color (cell_color),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Results cannot be held off: every done strobe is taken at the edge
  // that closes its cycle. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && done) shadow.check_result(cursor_pos, cell_char, cell_color);
  end

  function automatic console_req_t mk_req(input logic [1:0] kind, input logic [7:0] code,
                                          input logic [4:0] row, input logic [6:0] col);
    console_req_t r;
    r.kind = kind;
    r.code = code;
    r.row  = row;
    r.col  = col;
    return r;
  endfunction

  // Mostly puts, with control codes weighted up so that wraps, tabs over
  // row ends and scrolls come often; reads lean towards the cursor row,
  // where fresh characters land. Now and then a clear or a spare code.
  function automatic console_req_t random_request();
    console_req_t r;
    int unsigned  pick;
    r.kind = REQ_PUT;
    r.code = 8'($urandom_range(0, 255));
    r.row  = 5'($urandom_range(0, 31));
    r.col  = 7'($urandom_range(0, 127));
    pick   = $urandom_range(0, 999);
    if (pick < 560) begin
      // ordinary byte, any value
    end else if (pick < 640) begin
      r.code = CH_LF;
    end else if (pick < 680) begin
      r.code = CH_CR;
    end else if (pick < 740) begin
      r.code = CH_TAB;
    end else if (pick < 960) begin
      r.kind = REQ_READ;
      if ($urandom_range(0, 4) != 0) begin
        r.row = $urandom_range(0, 1) ? 5'(shadow.cur_row) : 5'($urandom_range(0, ROWS - 1));
        r.col = 7'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 975) begin
      r.kind = REQ_CLEAR;
    end else begin
      r.kind = REQ_SPARE;
    end
    return r;
  endfunction

  // Idle cycles ahead of a request: none, uniform 0..8, or mostly back to back.
  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 8);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    endcase
  endfunction

  // start stays high across back-to-back requests; it only drops for a gap.
  // Acceptance is the first edge with start high and busy low.
  task automatic issue(input console_req_t r, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= r.kind;
    char_code <= r.code;
    read_row  <= r.row;
    read_col  <= r.col;
    do @(posedge clk); while (busy);
    shadow.note_request(r);
  endtask

  // Idle the core: every owed report in and any sweep finished.
  task automatic drain();
    start <= 1'b0;
    while (shadow.owed_reports.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_blank_color(input logic [7:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow.blank_color = c;
  endtask

  initial begin
    console_req_t directed [$];
    logic [7:0]   phase_color [5];
    int unsigned  mode;
    shadow = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: first read lands only after the reset clearing pass, so it
    // sees character 0 in the reset colour. Then extreme bytes, both tab
    // lengths, CR, LF, corner and out-of-range reads, the spare code, clear.
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   8'd72,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   8'h00,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   8'hFF,   5'd31, 7'd127));
    directed.push_back(mk_req(REQ_PUT,   CH_TAB,  5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   CH_TAB,  5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   8'h80,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   CH_CR,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   8'h7F,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_PUT,   CH_LF,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_READ,  8'hFF,   5'd0,  7'd0));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd2));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd4));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd79));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd24, 7'd79));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd24, 7'd0));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd25, 7'd0));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd31, 7'd127));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd80));
    directed.push_back(mk_req(REQ_SPARE, 8'hFF,   5'd31, 7'd127));
    directed.push_back(mk_req(REQ_CLEAR, 8'd0,    5'd0,  7'd0));
    directed.push_back(mk_req(REQ_READ,  8'd0,    5'd0,  7'd1));
    foreach (directed[i]) issue(directed[i], draw_gap(i % 3));

    // Random phases, each behind a new blank colour, extremes first.
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = 8'($urandom_range(1, 254));
    phase_color[3] = 8'h80;
    phase_color[4] = COLOR_RST;
    mode = 0;
    foreach (phase_color[p]) begin
      set_blank_color(phase_color[p]);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // idling style changes every 50 requests so bursts and gaps both show
        if (i % 50 == 0) mode = $urandom_range(0, 2);
        issue(random_request(), draw_gap(mode));
      end
    end

    drain();
    // room for a stray strobe after a full sweep
    repeat (CELL_COUNT + 16) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond a run where every request sweeps the store.
  initial begin
    #100_000_000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/tmcw_pkg.sv
sv/tmcw_cell_store.sv
sv/text_mode_console_writer_core.sv
sim/testbench.sv
